@@ rtl/core/krt_pkg.sv @@
`timescale 1ns / 1ps
// krt_pkg: request, response and probe types plus command and status codes
// for the keyed record table; no dependencies

package krt_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EXISTS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic signed [31:0] AMT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] AMT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] part_key;
        logic [63:0]        part_label;
        logic signed [31:0] amount;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [63:0]        found_label;
        logic signed [31:0] found_amount;
    } rsp_t;

    // probe item that walks the cell row, one cell per cycle
    typedef struct packed {
        logic               active;
        logic [1:0]         cmd;
        logic signed [31:0] key;
        logic signed [31:0] delta;
        logic               hit;
        logic [63:0]        label;
        logic signed [31:0] qty;
    } probe_t;

endpackage

@@ rtl/core/krt_cell.sv @@
`timescale 1ns / 1ps
// krt_cell: one record slot of the table and one stage of the probe row
// depends on krt_pkg

module krt_cell #(
    parameter int CAPACITY    = 128,
    parameter int LABEL_BYTES = 8,
    parameter int IDX         = 0,
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int LBL_W      = 8 * LABEL_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CNT_W-1:0]    fill_count,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_idx,
    input  logic signed [31:0]  wr_key,
    input  logic [LBL_W-1:0]    wr_label,
    input  logic signed [31:0]  wr_amount,
    input  krt_pkg::probe_t     probe_in,
    output krt_pkg::probe_t     probe_out
);

    logic signed [31:0] key_reg;
    logic [LBL_W-1:0]   label_reg;
    logic signed [31:0] amount_reg;
    logic signed [31:0] amount_next;
    logic               act_reg;
    krt_pkg::probe_t    probe_reg;
    krt_pkg::probe_t    probe_next;
    logic               live;
    logic               match;
    logic signed [32:0] sum;
    logic signed [31:0] sat;

    assign live  = CNT_W'(IDX) < fill_count;
    assign match = probe_in.active && !probe_in.hit && live && (key_reg == probe_in.key);
    assign sum   = {amount_reg[31], amount_reg} + {probe_in.delta[31], probe_in.delta};

    always_comb
    begin
        if (sum[32] != sum[31])
        begin
            sat = sum[32] ? krt_pkg::AMT_MIN : krt_pkg::AMT_MAX;
        end
        else
        begin
            sat = sum[31:0];
        end
    end

    always_comb
    begin
        probe_next  = probe_in;
        amount_next = amount_reg;
        if (wr_en && (wr_idx == IDX_W'(IDX)))
        begin
            amount_next = wr_amount;
        end
        if (match)
        begin
            probe_next.hit = 1'b1;
            case (probe_in.cmd)
                krt_pkg::CMD_SEARCH:
                begin
                    probe_next.label = 64'(label_reg);
                    probe_next.qty   = amount_reg;
                end
                krt_pkg::CMD_UPDATE:
                begin
                    probe_next.qty = sat;
                    amount_next    = sat;
                end
                default:
                begin
                    probe_next.qty = probe_in.qty;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= probe_in.active;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg  <= probe_next;
        amount_reg <= amount_next;
        if (wr_en && (wr_idx == IDX_W'(IDX)))
        begin
            key_reg   <= wr_key;
            label_reg <= wr_label;
        end
    end

    always_comb
    begin
        probe_out        = probe_reg;
        probe_out.active = act_reg;
    end

endmodule

@@ rtl/core/keyed_record_table.sv @@
`timescale 1ns / 1ps
// keyed_record_table: top level, request control and the row of record cells
// depends on krt_pkg and krt_cell
//
//  channel   direction  payload           handshake
//  req       in         krt_pkg::req_t    req_valid / req_stall
//  rsp       out        krt_pkg::rsp_t    rsp_valid / rsp_stall
//
// search, update and non-full insert: probe walks all CAPACITY cells, one per
// cycle, and the response is registered from the last cell, with return to idle
// insert into a full table and the unused command answer in the next cycle
// one item at a time: req_stall is high from accept until the response is taken
// reset clears fill count and control; record contents are not cleared

module keyed_record_table #(
    parameter int CAPACITY    = 128,
    parameter int LABEL_BYTES = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  krt_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output krt_pkg::rsp_t   rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LBL_W = 8 * LABEL_BYTES;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    krt_pkg::probe_t    launch_reg, launch_next;
    logic               rsp_valid_reg, rsp_valid_next;
    krt_pkg::rsp_t      rsp_reg, rsp_next;
    krt_pkg::probe_t    chain [0:CAPACITY];
    krt_pkg::probe_t    tail;
    logic               accept;
    logic               finish;
    logic               wr_en;

    assign accept = req_valid && !req_stall;
    assign tail   = chain[CAPACITY];
    assign finish = (state_reg == S_SCAN) && tail.active;
    assign wr_en  = finish && (tail.cmd == krt_pkg::CMD_INSERT) && !tail.hit;
    assign chain[0] = launch_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            krt_cell #(
                .CAPACITY    (CAPACITY),
                .LABEL_BYTES (LABEL_BYTES),
                .IDX         (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .fill_count (fill_reg),
                .wr_en      (wr_en),
                .wr_idx     (fill_reg[IDX_W-1:0]),
                .wr_key     (tail.key),
                .wr_label   (tail.label[LBL_W-1:0]),
                .wr_amount  (tail.delta),
                .probe_in   (chain[gi]),
                .probe_out  (chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        launch_next    = launch_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        launch_next.active = 1'b0;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (accept)
        begin
            launch_next.cmd   = req.cmd;
            launch_next.key   = req.part_key;
            launch_next.delta = req.amount;
            launch_next.hit   = 1'b0;
            launch_next.label = req.part_label;
            launch_next.qty   = '0;
            rsp_next.found_label  = '0;
            rsp_next.found_amount = '0;
            if ((req.cmd == krt_pkg::CMD_INSERT) && (fill_reg >= CNT_W'(CAPACITY)))
            begin
                rsp_next.status = krt_pkg::ST_FULL;
                rsp_valid_next  = 1'b1;
            end
            else if ((req.cmd == krt_pkg::CMD_INSERT) || (req.cmd == krt_pkg::CMD_SEARCH) ||
                     (req.cmd == krt_pkg::CMD_UPDATE))
            begin
                launch_next.active = 1'b1;
                state_next         = S_SCAN;
            end
            else
            begin
                rsp_next.status = krt_pkg::ST_OK;
                rsp_valid_next  = 1'b1;
            end
        end

        if (finish)
        begin
            state_next            = S_IDLE;
            rsp_valid_next        = 1'b1;
            rsp_next.found_label  = '0;
            rsp_next.found_amount = '0;
            case (tail.cmd)
                krt_pkg::CMD_INSERT:
                begin
                    rsp_next.status = tail.hit ? krt_pkg::ST_EXISTS : krt_pkg::ST_OK;
                    if (!tail.hit)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                krt_pkg::CMD_SEARCH:
                begin
                    rsp_next.status = tail.hit ? krt_pkg::ST_OK : krt_pkg::ST_NOTFOUND;
                    if (tail.hit)
                    begin
                        rsp_next.found_label  = tail.label;
                        rsp_next.found_amount = tail.qty;
                    end
                end
                default:
                begin
                    rsp_next.status = tail.hit ? krt_pkg::ST_OK : krt_pkg::ST_NOTFOUND;
                    if (tail.hit)
                    begin
                        rsp_next.found_amount = tail.qty;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            launch_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            launch_reg    <= launch_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE) || rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (fill_reg < CNT_W'(CAPACITY)))
        else $error("record write into a full table");

    a_no_stray_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !tail.active)
        else $error("probe left the row while idle");

    a_scan_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !rsp_valid_reg)
        else $error("response pending during scan");

    a_finish_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (rsp_valid_reg && (state_reg == S_IDLE)))
        else $error("scan end without response");

endmodule
